FILE: rtl/core/blx_pkg.sv
// Package of shared types, constants and character classes for the byte stream lexer.
`default_nettype none
package blx_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OP,
        ST_RUN
    } t_state;

    localparam logic [1:0] KIND_OP    = 2'd0;
    localparam logic [1:0] KIND_KEYW  = 2'd1;
    localparam logic [1:0] KIND_IDENT = 2'd2;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_S     = 8'h73;

    typedef struct packed {
        logic       append;
        logic       shift;
        logic [7:0] data;
    } t_chain_ctl;

    function automatic logic is_alnum(input logic [7:0] c);
        is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        is_oper = (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2F) || (c == 8'h2A) ||
                  (c == CH_PCT) || (c == 8'h3C) || (c == 8'h3E) || (c == 8'h3D);
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        logic d;
        case (c)
            CH_SPACE, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h2C, 8'h3B, 8'h3C, 8'h3E, 8'h3D,
            8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, CH_NL, CH_TAB, 8'h22, 8'h27: begin
                d = 1'b1;
            end
            default: begin
                d = 1'b0;
            end
        endcase
        is_delim = d;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/blx_cell.sv
// One character cell of the token chain: loads an appended byte or takes its right neighbor.
`default_nettype none
module blx_cell
    import blx_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_load,
    input  wire logic       i_shift,
    input  wire logic [7:0] i_char,
    input  wire logic [7:0] i_right,
    output logic [7:0]      o_char
);

    logic [7:0] r_char;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_char <= i_right;
        end else if (i_load) begin
            r_char <= i_char;
        end
    end

    assign o_char = r_char;

endmodule
`default_nettype wire

FILE: rtl/core/blx_chain.sv
// Row of character cells that holds the token and drains it toward cell zero.
`default_nettype none
module blx_chain
    import blx_pkg::*;
#(
    parameter int MAX_TOKEN = 24,
    parameter int CW        = 5
) (
    input  wire logic          i_clk,
    input  wire t_chain_ctl    i_ctl,
    input  wire logic [CW-1:0] i_wr_pos,
    output logic [7:0]         o_cells [MAX_TOKEN]
);

    logic [7:0] w_right [MAX_TOKEN];

    genvar g;
    generate
        for (g = 0; g < MAX_TOKEN; g++) begin : g_cell
            if (g == MAX_TOKEN - 1) begin : g_end
                assign w_right[g] = 8'h00;
            end else begin : g_mid
                assign w_right[g] = o_cells[g+1];
            end
            blx_cell u_cell (
                .i_clk   (i_clk),
                .i_load  (i_ctl.append && (i_wr_pos == CW'(g))),
                .i_shift (i_ctl.shift),
                .i_char  (i_ctl.data),
                .i_right (w_right[g]),
                .o_char  (o_cells[g])
            );
        end
    endgenerate

endmodule
`default_nettype wire

FILE: rtl/core/byte_stream_lexer.sv
// Top level of the byte stream lexer: classification, control and the result register.
//
//  Channel | Handshake                   | Payload
//  --------+-----------------------------+------------------------------------------
//  input   | i_in_valid / o_in_ready     | i_char_in
//  output  | o_out_valid / i_out_ready   | o_token_kind, o_line_number, o_char_value,
//          |                             | o_char_index, o_token_length, o_truncated,
//          |                             | o_last_of_run
//
// A byte that causes results holds off further input while each result leaves through
// the single output register, and the token drains from the cell chain one character
// per cycle while the output register is free to take it.
// Input is taken only while no result of the previous byte remains to be loaded.
// A stalled output holds the result register unchanged and keeps the chain from draining.
// Reset clears the character count, the overflow flag, the control state and sets
// the line counter to one.
`default_nettype none
module byte_stream_lexer
    import blx_pkg::*;
#(
    parameter int MAX_TOKEN = 24,
    parameter int LINE_BITS = 20
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_char_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_token_kind,
    output logic [19:0]     o_line_number,
    output logic [7:0]      o_char_value,
    output logic [4:0]      o_char_index,
    output logic [4:0]      o_token_length,
    output logic            o_truncated,
    output logic            o_last_of_run
);

    localparam int CW = $clog2(MAX_TOKEN + 1);

    t_state r_state, n_state;

    logic [CW-1:0]        r_count;
    logic                 r_ovf;
    logic [LINE_BITS-1:0] r_line;

    logic [1:0]           r_kind;
    logic [CW-1:0]        r_len;
    logic                 r_trunc;
    logic [LINE_BITS-1:0] r_line_tok;
    logic [7:0]           r_op_char;
    logic                 r_run_pend;
    logic [CW-1:0]        r_idx;

    logic                 r_out_valid;
    logic [1:0]           r_o_kind;
    logic [7:0]           r_o_char;
    logic [CW-1:0]        r_o_idx;
    logic [CW-1:0]        r_o_len;
    logic                 r_o_trunc;
    logic                 r_o_last;
    logic [LINE_BITS-1:0] r_o_line;

    logic       w_accept;
    logic       w_alnum;
    logic       w_oper;
    logic       w_run_start;
    logic       w_keyword;
    logic       w_slot_free;
    logic       w_run_last;
    logic       w_load_op;
    logic       w_load_run;
    logic [7:0] w_cells [MAX_TOKEN];
    t_chain_ctl w_ctl;

    logic [LINE_BITS+19:0] w_line_ext;
    logic [CW+4:0]         w_idx_ext;
    logic [CW+4:0]         w_len_ext;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_alnum     = is_alnum(i_char_in);
    assign w_oper      = is_oper(i_char_in);
    assign w_run_start = is_delim(i_char_in) && (r_count != '0);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_run_last  = (r_idx == r_len - CW'(1));

    assign w_keyword = !r_ovf &&
        (((r_count == CW'(2)) && (w_cells[0] == CH_I) && (w_cells[1] == CH_F)) ||
         ((r_count == CW'(4)) && (w_cells[0] == CH_E) && (w_cells[1] == CH_L) &&
          (w_cells[2] == CH_S) && (w_cells[3] == CH_E)));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_oper) begin
                    n_state = ST_OP;
                end else if (w_accept && w_run_start) begin
                    n_state = ST_RUN;
                end
            end
            ST_OP: begin
                if (w_slot_free) begin
                    n_state = r_run_pend ? ST_RUN : ST_IDLE;
                end
            end
            ST_RUN: begin
                if (w_slot_free && w_run_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_load_op  = 1'b0;
        w_load_run = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_OP: begin
                w_load_op = w_slot_free;
            end
            ST_RUN: begin
                w_load_run = w_slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_ctl.append = w_accept && w_alnum && (r_count < CW'(MAX_TOKEN));
        w_ctl.shift  = w_load_run;
        w_ctl.data   = i_char_in;
    end

    blx_chain #(
        .MAX_TOKEN (MAX_TOKEN),
        .CW        (CW)
    ) u_chain (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_wr_pos (r_count),
        .o_cells  (w_cells)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_line      <= LINE_BITS'(1);
            r_out_valid <= 1'b0;
            r_run_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_run_pend <= w_run_start;
                if (w_ctl.append) begin
                    r_count <= r_count + CW'(1);
                end else if (w_alnum) begin
                    r_ovf <= 1'b1;
                end
                if (w_run_start) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
                if ((i_char_in == CH_NL) && (r_line != {LINE_BITS{1'b1}})) begin
                    r_line <= r_line + LINE_BITS'(1);
                end
            end
            if (w_load_op || w_load_run) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind     <= w_keyword ? KIND_KEYW : KIND_IDENT;
            r_len      <= r_count;
            r_trunc    <= r_ovf;
            r_line_tok <= r_line;
            r_op_char  <= i_char_in;
            r_idx      <= '0;
        end else if (w_load_run) begin
            r_idx <= r_idx + CW'(1);
        end
        if (w_load_op) begin
            r_o_kind  <= KIND_OP;
            r_o_char  <= r_op_char;
            r_o_idx   <= '0;
            r_o_len   <= CW'(1);
            r_o_trunc <= 1'b0;
            r_o_last  <= !r_run_pend;
            r_o_line  <= r_line_tok;
        end else if (w_load_run) begin
            r_o_kind  <= r_kind;
            r_o_char  <= w_cells[0];
            r_o_idx   <= r_idx;
            r_o_len   <= r_len;
            r_o_trunc <= r_trunc;
            r_o_last  <= w_run_last;
            r_o_line  <= r_line_tok;
        end
    end

    assign w_line_ext = {20'd0, r_o_line};
    assign w_idx_ext  = {5'd0, r_o_idx};
    assign w_len_ext  = {5'd0, r_o_len};

    assign o_out_valid    = r_out_valid;
    assign o_token_kind   = r_o_kind;
    assign o_line_number  = w_line_ext[19:0];
    assign o_char_value   = r_o_char;
    assign o_char_index   = w_idx_ext[4:0];
    assign o_token_length = w_len_ext[4:0];
    assign o_truncated    = r_o_trunc;
    assign o_last_of_run  = r_o_last;

endmodule
`default_nettype wire
